[rtl/core/rse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack evaluator package
// Shared constants, operation codes and the request and response types that
// pass between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int WORD_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam int MUL_STEPS   = 32;
  localparam int DIV_STEPS   = 48;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POP  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic                     start;
    alu_op_t                  op;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

[rtl/core/rpn_stack_evaluator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack evaluator core
// Reverse Polish evaluator over a 128-entry stack of signed Q16.16 values.
//
// The input channel takes one token per item: an operation code and a value
// used by push. The output channel returns one item per token with the value,
// the four error flags and the stack level after the token.
// The core works on one item at a time and holds in_stall high from the
// acceptance of an item until its result is loaded into the output register.
// Push and unknown codes load their result directly; pop and a zero divisor
// finish after the divisor check; add, subtract, multiply and divide wait for
// the arithmetic unit, and a pop that finds the stack empty skips its RAM read.
// The next item is accepted after the load. The time is set by the shared
// 33-bit adder, which produces one product or quotient bit per cycle over 32
// or 48 steps, and by the registered read of the stack RAM.
// The output register is separate, so a new item is accepted while a result
// waits; a token that finishes while the previous result is still stalled
// waits in the result stage until the output register is taken.
// Reset empties the stack and clears both valids; the stack RAM contents are
// not cleared and are never read before written.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core
  import rse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         operation,
  input  wire logic signed [31:0] operand_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      result_value,
  output logic                    underflow_error,
  output logic                    overflow_error,
  output logic                    zero_divisor_error,
  output logic                    unknown_command_error,
  output logic [7:0]              stack_level
);

  typedef enum logic [2:0] {
    S_IDLE, S_POP_R, S_GET_R, S_CHK, S_POP_L, S_GET_L, S_EXEC, S_WAIT
  } seq_state_t;

  seq_state_t               state;
  logic                     in_done;
  opcode_t                  op_r;
  alu_op_t                  alu_op;
  logic [SP_W-1:0]          sp;
  logic signed [WORD_W-1:0] value;
  logic signed [WORD_W-1:0] left;
  logic signed [WORD_W-1:0] right;
  logic                     under;
  logic                     zdiv;
  logic                     unknown;
  logic                     do_push;

  logic [SP_W-1:0]   sp_m1;
  logic [SP_W-1:0]   sp_p1;
  logic              full;
  logic              slot_free;
  logic              push_ok;
  logic [WORD_W-1:0] rd_data;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign sp_m1     = sp - SP_W'(1);
  assign sp_p1     = sp + SP_W'(1);
  assign full      = (sp == SP_W'(STACK_DEPTH));
  assign slot_free = !out_valid || !out_stall;
  assign push_ok   = in_done && slot_free && do_push && !full;
  assign in_stall  = (state != S_IDLE) || in_done;

  rse_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (push_ok),
    .waddr(sp[ADDR_W-1:0]),
    .wdata(value),
    .raddr(sp_m1[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  assign alu_req.start = (state == S_EXEC);
  assign alu_req.op    = alu_op;
  assign alu_req.a     = left;
  assign alu_req.b     = right;

  rse_alu u_alu (
    .clk(clk),
    .rst(rst),
    .req(alu_req),
    .rsp(alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_done   <= 1'b0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // A finished token reloads the output register in the same cycle.
      if (out_valid && !out_stall && !in_done) begin
        out_valid <= 1'b0;
      end

      if (in_done) begin
        // Result stage: push if asked, then load the output register.
        if (slot_free) begin
          result_value          <= value;
          underflow_error       <= under;
          overflow_error        <= do_push && full;
          zero_divisor_error    <= zdiv;
          unknown_command_error <= unknown;
          stack_level           <= 8'(push_ok ? sp_p1 : sp);
          if (push_ok) begin
            sp <= sp_p1;
          end
          out_valid <= 1'b1;
          in_done   <= 1'b0;
        end
      end else begin
        unique case (state)
          S_IDLE: begin
            if (in_valid) begin
              op_r    <= opcode_t'(operation);
              under   <= 1'b0;
              zdiv    <= 1'b0;
              unknown <= (operation > OP_POP);
              do_push <= (opcode_t'(operation) == OP_PUSH);
              value   <= (opcode_t'(operation) == OP_PUSH) ? operand_value : '0;
              case (opcode_t'(operation))
                OP_PUSH: begin
                  in_done <= 1'b1;
                end
                OP_ADD: begin
                  alu_op <= ALU_ADD;
                  state  <= S_POP_R;
                end
                OP_SUB: begin
                  alu_op <= ALU_SUB;
                  state  <= S_POP_R;
                end
                OP_MUL: begin
                  alu_op <= ALU_MUL;
                  state  <= S_POP_R;
                end
                OP_DIV: begin
                  alu_op <= ALU_DIV;
                  state  <= S_POP_R;
                end
                OP_POP: begin
                  state <= S_POP_R;
                end
                default: begin
                  in_done <= 1'b1;
                end
              endcase
            end
          end
          S_POP_R: begin
            if (sp == '0) begin
              right <= '0;
              under <= 1'b1;
              state <= S_CHK;
            end else begin
              sp    <= sp_m1;
              state <= S_GET_R;
            end
          end
          S_GET_R: begin
            right <= rd_data;
            state <= S_CHK;
          end
          S_CHK: begin
            if (op_r == OP_POP) begin
              value   <= right;
              in_done <= 1'b1;
              state   <= S_IDLE;
            end else if ((op_r == OP_DIV) && (right == '0)) begin
              zdiv    <= 1'b1;
              in_done <= 1'b1;
              state   <= S_IDLE;
            end else begin
              state <= S_POP_L;
            end
          end
          S_POP_L: begin
            if (sp == '0) begin
              left  <= '0;
              under <= 1'b1;
              state <= S_EXEC;
            end else begin
              sp    <= sp_m1;
              state <= S_GET_L;
            end
          end
          S_GET_L: begin
            left  <= rd_data;
            state <= S_EXEC;
          end
          S_EXEC: begin
            state <= S_WAIT;
          end
          S_WAIT: begin
            if (alu_rsp.done) begin
              value   <= alu_rsp.result;
              do_push <= 1'b1;
              in_done <= 1'b1;
              state   <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // The stack pointer never passes the stack depth.
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // The arithmetic unit only answers while the sequencer waits for it.
  a_alu_done: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == S_WAIT) && !in_done)
    else $error("arithmetic result arrived outside the wait state");

  // A zero divisor gives a zero value and never pushes.
  a_zdiv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor_error) |-> (result_value == '0) && !overflow_error)
    else $error("zero divisor result is not clean");

  // An unknown code touches nothing else.
  a_unknown: assert property (@(posedge clk) disable iff (rst)
    (out_valid && unknown_command_error) |->
      !underflow_error && !overflow_error && !zero_divisor_error)
    else $error("unknown code raised another error");

  // A push that fits raises the level by one at the result load.
  a_push_level: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> (sp == $past(sp_p1)))
    else $error("stack level did not follow a push");

endmodule
`default_nettype wire

[rtl/core/rse_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/rse_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack evaluator arithmetic unit
// One 33-bit adder serves add and subtract in a single pass, shift-add
// multiply one bit per cycle and restoring divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rse_alu
  import rse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIX} alu_state_t;

  alu_state_t          state;
  alu_op_t             op;
  logic                neg;
  logic [WORD_W-1:0]   mop;
  logic [WORD_W-1:0]   hi;
  logic [47:0]         lo;
  logic [STEP_W-1:0]   cnt;
  logic                done;
  logic signed [WORD_W-1:0] result;

  logic [32:0]       add_x;
  logic [32:0]       add_y;
  logic              add_sub;
  logic [33:0]       add_sum;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;
  logic [32:0]       div_shift;
  logic              borrow;
  logic [47:0]       mag;
  logic              mag_big;
  logic              mag_ovf;
  logic signed [WORD_W-1:0] sat_addsub;
  logic signed [WORD_W-1:0] fixed_val;

  assign mag_a = req.a[WORD_W-1] ? (~req.a + 32'd1) : req.a;
  assign mag_b = req.b[WORD_W-1] ? (~req.b + 32'd1) : req.b;

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (op)
      ALU_ADD, ALU_SUB: begin
        add_x   = {hi[WORD_W-1], hi};
        add_y   = {mop[WORD_W-1], mop};
        add_sub = (op == ALU_SUB);
      end
      ALU_MUL: begin
        add_x = {1'b0, hi};
        add_y = lo[0] ? {1'b0, mop} : 33'd0;
      end
      default: begin
        add_x   = {hi, lo[47]};
        add_y   = {1'b0, mop};
        add_sub = 1'b1;
      end
    endcase
    add_sum = {1'b0, add_x} + (add_sub ? {1'b1, ~add_y} : {1'b0, add_y})
              + {33'd0, add_sub};
  end

  assign div_shift = {hi, lo[47]};
  assign borrow    = add_sum[33];

  // A 33-bit sum whose top two bits differ lies outside the Q16.16 range.
  assign sat_addsub = (add_sum[32] != add_sum[31]) ? (add_sum[32] ? Q_MIN : Q_MAX)
                                                   : add_sum[31:0];

  assign mag     = (op == ALU_MUL) ? {hi, lo[31:16]} : lo;
  assign mag_big = (|mag[47:32]);
  // Magnitude above 2^31 saturates either way; exactly 2^31 fits only if negative.
  assign mag_ovf = mag_big || (mag[31] && ((|mag[30:0]) || !neg));

  always_comb begin
    if (mag_ovf) begin
      fixed_val = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      fixed_val = ~mag[31:0] + 32'd1;
    end else begin
      fixed_val = mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        A_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            op    <= req.op;
            neg   <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
            cnt   <= '0;
            state <= A_RUN;
            case (req.op)
              ALU_ADD, ALU_SUB: begin
                hi  <= req.a;
                mop <= req.b;
              end
              ALU_MUL: begin
                hi  <= '0;
                lo  <= {16'd0, mag_b};
                mop <= mag_a;
              end
              default: begin
                hi  <= '0;
                lo  <= {mag_a, 16'd0};
                mop <= mag_b;
              end
            endcase
          end
        end
        A_RUN: begin
          cnt <= cnt + STEP_W'(1);
          case (op)
            ALU_ADD, ALU_SUB: begin
              result <= sat_addsub;
              done   <= 1'b1;
              state  <= A_IDLE;
            end
            ALU_MUL: begin
              done <= 1'b0;
              hi   <= add_sum[32:1];
              lo   <= {16'd0, add_sum[0], lo[31:1]};
              if (cnt == STEP_W'(MUL_STEPS - 1)) begin
                state <= A_FIX;
              end
            end
            default: begin
              done <= 1'b0;
              hi   <= borrow ? div_shift[31:0] : add_sum[31:0];
              lo   <= {lo[46:0], ~borrow};
              if (cnt == STEP_W'(DIV_STEPS - 1)) begin
                state <= A_FIX;
              end
            end
          endcase
        end
        A_FIX: begin
          result <= fixed_val;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule
`default_nettype wire
